### rtl/emt_pkg.sv
// emt_pkg: shared types and constants of the extent map translator
// holds config, queue item, status and state encodings
// no dependencies
package emt_pkg;

  localparam int POS_W       = 48;
  localparam int LEN_W       = 32;
  localparam int BS_W        = 17;
  localparam int SZ_W        = LEN_W + BS_W;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_WRITE     = 1'b0,
    CMD_TRANSLATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST_END = 2'd1,
    ST_NEGATIVE = 2'd2
  } result_code_t;

  typedef enum logic [1:0] {
    CFG_MAP_MODE  = 2'd0,
    CFG_BLK_BYTES = 2'd1,
    CFG_PART_BASE = 2'd2,
    CFG_RUN_COUNT = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_NEGATIVE  = 2'd1,
    KIND_TRANSLATE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_WALK = 2'd1,
    BK_FIN1 = 2'd2,
    BK_FIN2 = 2'd3
  } back_state_t;

  typedef struct packed {
    logic              map_mode;
    logic [BS_W-1:0]   blk_bytes;
    logic [POS_W-1:0]  partition_base;
    logic [4:0]        run_count;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        slot;
    logic [LEN_W-1:0]  run_start;
    logic [LEN_W-1:0]  run_length;
    logic [POS_W-2:0]  position;
    logic [LEN_W-1:0]  request_length;
  } item_t;

endpackage

### rtl/extent_map_translator_top.sv
// extent_map_translator_top: extent run list address translation
// holds the configuration registers and joins front, queue and back
// depends on emt_pkg, emt_front, emt_queue, emt_back
//
// Input channel in_valid/in_stall carries one transaction: cmd 0 stores
// run_start/run_length at run_slot, cmd 1 translates byte_position for
// request_length bytes. Every transaction gives exactly one result on the
// out_valid/out_stall channel (status, phys_position, grant_length,
// run_hit, total_size). Configuration goes through cfg_write, cfg_index and
// cfg_data; index 0 map mode, 1 block size, 2 partition base, 3 run count.
// The front stage and the two-entry queue lie ahead of the back
// end. A write or a negative position goes straight to the result register.
// A translate reads min(run_count, MAX_RUNS) run memory entries, one
// entry per cycle, followed by scale, accumulate, the finishing states
// FIN1 and FIN2 and the result register.
// The back end takes one transaction at a time; the queue keeps accepting
// while a result waits under out_stall. Reset restores the register reset
// values and empties the pipeline; run memory contents are not cleared.
module extent_map_translator_top #(
  parameter int MAX_RUNS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [emt_pkg::POS_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [3:0]                       run_slot,
  input  logic [emt_pkg::LEN_W-1:0]        run_start,
  input  logic [emt_pkg::LEN_W-1:0]        run_length,
  input  logic signed [emt_pkg::POS_W-1:0] byte_position,
  input  logic [emt_pkg::LEN_W-1:0]        request_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [emt_pkg::POS_W-1:0]        phys_position,
  output logic [emt_pkg::LEN_W-1:0]        grant_length,
  output logic [3:0]                       run_hit,
  output logic [emt_pkg::POS_W-1:0]        total_size
);

  emt_pkg::cfg_t  cfg;
  logic           push_valid;
  emt_pkg::item_t push_item;
  logic           queue_full;
  logic           q_pop;
  logic           q_valid;
  emt_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_mode       <= 1'b0;
      cfg.blk_bytes      <= emt_pkg::BS_W'(512);
      cfg.partition_base <= '0;
      cfg.run_count      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        emt_pkg::CFG_MAP_MODE:  cfg.map_mode       <= cfg_data[0];
        emt_pkg::CFG_BLK_BYTES: cfg.blk_bytes      <= cfg_data[emt_pkg::BS_W-1:0];
        emt_pkg::CFG_PART_BASE: cfg.partition_base <= cfg_data;
        emt_pkg::CFG_RUN_COUNT: cfg.run_count      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  emt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .run_slot       (run_slot),
    .run_start      (run_start),
    .run_length     (run_length),
    .byte_position  (byte_position),
    .request_length (request_length),
    .push_valid     (push_valid),
    .push_item      (push_item),
    .queue_full     (queue_full)
  );

  emt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  emt_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .phys_position (phys_position),
    .grant_length  (grant_length),
    .run_hit       (run_hit),
    .total_size    (total_size)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_simple_result: assert property (@(posedge clk) disable iff (rst)
    q_pop && (q_item.kind != emt_pkg::KIND_TRANSLATE) |=> out_valid)
    else $error("write or negative transaction gave no result");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_negative_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == emt_pkg::ST_NEGATIVE) |->
      (phys_position == '0) && (grant_length == '0) && (total_size == '0))
    else $error("negative position result carries data");

endmodule

### rtl/emt_front.sv
// emt_front: input stage of the extent map translator
// registers one transaction and classifies it as write, negative or translate
// depends on emt_pkg
module emt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [3:0]                    run_slot,
  input  logic [emt_pkg::LEN_W-1:0]     run_start,
  input  logic [emt_pkg::LEN_W-1:0]     run_length,
  input  logic signed [emt_pkg::POS_W-1:0] byte_position,
  input  logic [emt_pkg::LEN_W-1:0]     request_length,
  output logic                          push_valid,
  output emt_pkg::item_t                push_item,
  input  logic                          queue_full
);

  logic           valid;
  emt_pkg::item_t item;
  emt_pkg::kind_t kind;
  logic           accept;

  assign in_stall   = valid && queue_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = valid;
  assign push_item  = item;

  always_comb begin
    if (cmd == emt_pkg::CMD_WRITE) begin
      kind = emt_pkg::KIND_WRITE;
    end else if (byte_position[emt_pkg::POS_W-1]) begin
      kind = emt_pkg::KIND_NEGATIVE;
    end else begin
      kind = emt_pkg::KIND_TRANSLATE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (!queue_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind           <= kind;
      item.slot           <= run_slot;
      item.run_start      <= run_start;
      item.run_length     <= run_length;
      item.position       <= byte_position[emt_pkg::POS_W-2:0];
      item.request_length <= request_length;
    end
  end

endmodule

### rtl/emt_queue.sv
// emt_queue: short fifo between front and back of the extent map translator
// holds classified transactions so each side can stall on its own
// depends on emt_pkg
module emt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  emt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output emt_pkg::item_t pop_item
);

  localparam int PW = (emt_pkg::QUEUE_DEPTH > 1) ? $clog2(emt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(emt_pkg::QUEUE_DEPTH + 1);

  emt_pkg::item_t slots [emt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push_ok;
  logic           pop_ok;

  assign full      = (count == CW'(emt_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign push_ok   = push_valid && !full;
  assign pop_ok    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(emt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(emt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/emt_back.sv
// emt_back: execution side of the extent map translator
// owns the run memory, walks runs one per cycle and drives the result register
// depends on emt_pkg
module emt_back #(
  parameter int MAX_RUNS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  emt_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  input  emt_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [emt_pkg::POS_W-1:0] phys_position,
  output logic [emt_pkg::LEN_W-1:0] grant_length,
  output logic [3:0]                run_hit,
  output logic [emt_pkg::POS_W-1:0] total_size
);

  localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CNT_W = $clog2(MAX_RUNS + 1);
  localparam int RC_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int ACC_W = emt_pkg::SZ_W + CNT_W;
  localparam int POS_W = emt_pkg::POS_W;
  localparam int LEN_W = emt_pkg::LEN_W;
  localparam int SZ_W  = emt_pkg::SZ_W;

  emt_pkg::back_state_t state, state_next;

  logic [2*LEN_W-1:0] run_mem [MAX_RUNS];
  logic [2*LEN_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_v;

  logic [CNT_W-1:0]   n_runs;
  logic [CNT_W-1:0]   iss_cnt;
  logic               issue_done;
  logic               issue;

  logic [SZ_W-1:0]    len_bytes;
  logic [SZ_W-1:0]    org_bytes;
  logic [SZ_W-1:0]    mul_sz;
  logic [SZ_W-1:0]    mul_org;
  logic [IDX_W-1:0]   mul_idx;
  logic               mul_v;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_sum;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [POS_W-2:0]   hit_off;
  logic [SZ_W-1:0]    hit_sz;
  logic [SZ_W-1:0]    hit_org;

  logic [POS_W-2:0]   pos;
  logic [LEN_W-1:0]   req;
  logic [POS_W-2:0]   run_off;
  logic [POS_W-1:0]   total_sat;
  logic [SZ_W-1:0]    left;

  logic               out_free;
  logic               simple_done;
  logic               slot_ok;

  // run count saturates at the table depth
  always_comb begin
    if (RC_W'(cfg.run_count) > RC_W'(MAX_RUNS)) begin
      n_runs = CNT_W'(MAX_RUNS);
    end else begin
      n_runs = CNT_W'(cfg.run_count);
    end
  end

  assign out_free    = !out_valid || !out_stall;
  assign issue_done  = (iss_cnt == n_runs);
  assign issue       = (state == emt_pkg::BK_WALK) && !issue_done;
  assign rd_addr     = iss_cnt[IDX_W-1:0];
  assign simple_done = q_pop && (q_item.kind != emt_pkg::KIND_TRANSLATE);
  assign slot_ok     = (int'(q_item.slot) < MAX_RUNS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= emt_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      emt_pkg::BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.kind == emt_pkg::KIND_TRANSLATE) begin
            state_next = emt_pkg::BK_WALK;
          end
        end
      end
      emt_pkg::BK_WALK: begin
        if (issue_done && !rd_v && !mul_v) begin
          state_next = emt_pkg::BK_FIN1;
        end
      end
      emt_pkg::BK_FIN1: state_next = emt_pkg::BK_FIN2;
      emt_pkg::BK_FIN2: state_next = emt_pkg::BK_IDLE;
      default:          state_next = emt_pkg::BK_IDLE;
    endcase
  end

  // run memory
  always_ff @(posedge clk) begin
    if (q_pop && (q_item.kind == emt_pkg::KIND_WRITE) && slot_ok) begin
      run_mem[IDX_W'(q_item.slot)] <= {q_item.run_length, q_item.run_start};
    end
    rd_data <= run_mem[rd_addr];
  end

  // walk pipeline: read, scale, accumulate
  always_comb begin
    if (cfg.map_mode) begin
      len_bytes = SZ_W'(rd_data[2*LEN_W-1:LEN_W]);
      org_bytes = SZ_W'(rd_data[LEN_W-1:0]);
    end else begin
      len_bytes = SZ_W'(rd_data[2*LEN_W-1:LEN_W]) * SZ_W'(cfg.blk_bytes);
      org_bytes = SZ_W'(rd_data[LEN_W-1:0]) * SZ_W'(cfg.blk_bytes);
    end
  end

  assign acc_sum = acc + ACC_W'(mul_sz);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v    <= 1'b0;
      mul_v   <= 1'b0;
      iss_cnt <= '0;
      found   <= 1'b0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
      if (q_pop) begin
        iss_cnt <= '0;
        found   <= 1'b0;
      end else begin
        if (issue) begin
          iss_cnt <= iss_cnt + 1'b1;
        end
        if (mul_v && !found && (acc_sum > ACC_W'(pos))) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= rd_addr;
    mul_idx <= rd_idx;
    mul_sz  <= len_bytes;
    mul_org <= org_bytes;
    if (q_pop) begin
      acc <= '0;
      pos <= q_item.position;
      req <= q_item.request_length;
    end else if (mul_v) begin
      acc <= acc_sum;
      if (!found && (acc_sum > ACC_W'(pos))) begin
        hit_idx <= mul_idx;
        hit_off <= acc[POS_W-2:0];
        hit_sz  <= mul_sz;
        hit_org <= mul_org;
      end
    end
    if (state == emt_pkg::BK_FIN1) begin
      run_off <= pos - hit_off;
      if (acc > ACC_W'({POS_W{1'b1}})) begin
        total_sat <= {POS_W{1'b1}};
      end else begin
        total_sat <= acc[POS_W-1:0];
      end
    end
  end

  assign left = hit_sz - SZ_W'(run_off);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (simple_done || (state == emt_pkg::BK_FIN2)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (simple_done) begin
      status        <= (q_item.kind == emt_pkg::KIND_NEGATIVE) ? emt_pkg::ST_NEGATIVE
                                                               : emt_pkg::ST_OK;
      phys_position <= '0;
      grant_length  <= '0;
      run_hit       <= '0;
      total_size    <= '0;
    end else if (state == emt_pkg::BK_FIN2) begin
      total_size <= total_sat;
      if (found) begin
        status        <= emt_pkg::ST_OK;
        phys_position <= cfg.partition_base + hit_org[POS_W-1:0] + POS_W'(run_off);
        grant_length  <= (SZ_W'(req) < left) ? req : left[LEN_W-1:0];
        run_hit       <= 4'(hit_idx);
      end else begin
        status        <= emt_pkg::ST_PAST_END;
        phys_position <= '0;
        grant_length  <= '0;
        run_hit       <= '0;
      end
    end
  end

endmodule

### sim/extent_map_translator_top_tb.sv
// extent_map_translator_top_tb: directed and random check of extent run translation
// predicts every result from its own run table and register copy, compares in order
// depends on emt_pkg and extent_map_translator_top
module extent_map_translator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUNS = 16;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam longint unsigned POS_LIMIT = 64'h8000_0000_0000;

  typedef struct {
    emt_pkg::result_code_t status;
    logic [47:0] phys;
    logic [31:0] grant;
    logic [3:0]  hit;
    logic [47:0] total;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = emt_pkg::CFG_MAP_MODE;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = emt_pkg::CMD_WRITE;
  logic [3:0]  run_slot = '0;
  logic [31:0] run_start = '0;
  logic [31:0] run_length = '0;
  logic [47:0] byte_position = '0;
  logic [31:0] request_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [47:0] phys_position;
  logic [31:0] grant_length;
  logic [3:0]  run_hit;
  logic [47:0] total_size;

  logic [31:0] ext_start [MAX_RUNS];
  logic [31:0] ext_length [MAX_RUNS];
  logic        map_mode_q = 1'b0;
  logic [16:0] blk_bytes_q = 17'd512;
  logic [47:0] part_base_q = '0;
  logic [4:0]  run_count_q = '0;

  reply_t      pending_replies [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;

  extent_map_translator_top u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .run_slot       (run_slot),
    .run_start      (run_start),
    .run_length     (run_length),
    .byte_position  (byte_position),
    .request_length (request_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .phys_position  (phys_position),
    .grant_length   (grant_length),
    .run_hit        (run_hit),
    .total_size     (total_size)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("extent_map_translator_top_tb NOT OK");
      $finish;
    end
  end

  function automatic int active_runs();
    return (run_count_q > MAX_RUNS) ? MAX_RUNS : int'(run_count_q);
  endfunction

  function automatic longint unsigned run_bytes_of(int i);
    longint unsigned len;
    len = ext_length[i];
    return map_mode_q ? len : len * blk_bytes_q;
  endfunction

  function automatic longint unsigned run_origin_of(int i);
    longint unsigned st;
    st = ext_start[i];
    return map_mode_q ? st : st * blk_bytes_q;
  endfunction

  function automatic longint unsigned mapped_bytes();
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < active_runs(); i++) sum += run_bytes_of(i);
    return sum;
  endfunction

  function automatic reply_t predict_reply(emt_pkg::cmd_t c, logic [3:0] slot,
                                           logic [31:0] st, logic [31:0] len,
                                           logic [47:0] pos, logic [31:0] req);
    reply_t r;
    longint unsigned sum, off, sz, run_off, left, phys;
    int hit;
    bit found;
    r.status = emt_pkg::ST_OK;
    r.phys = '0;
    r.grant = '0;
    r.hit = '0;
    r.total = '0;
    if (c == emt_pkg::CMD_WRITE) begin
      ext_start[slot] = st;
      ext_length[slot] = len;
      return r;
    end
    if (pos[47]) begin
      r.status = emt_pkg::ST_NEGATIVE;
      return r;
    end
    sum = mapped_bytes();
    r.total = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
    off = 0;
    hit = 0;
    found = 1'b0;
    for (int i = 0; i < active_runs() && !found; i++) begin
      sz = run_bytes_of(i);
      if (off + sz > pos) begin
        hit = i;
        found = 1'b1;
      end else begin
        off += sz;
      end
    end
    if (!found) begin
      r.status = emt_pkg::ST_PAST_END;
      return r;
    end
    run_off = pos - off;
    left = run_bytes_of(hit) - run_off;
    phys = part_base_q + run_origin_of(hit) + run_off;
    r.phys = phys[47:0];
    r.grant = (req < left) ? req : left[31:0];
    r.hit = 4'(hit);
    return r;
  endfunction

  // position inside a non-empty run (first or last byte when at_edge); a random non-negative position if none fits
  function automatic logic [47:0] pick_target(bit at_edge);
    int cand [$];
    int idx;
    longint unsigned off, sz, run_off, p;
    for (int i = 0; i < active_runs(); i++)
      if (run_bytes_of(i) != 0) cand.push_back(i);
    if (cand.size() == 0) return {1'b0, 47'({$urandom, $urandom})};
    idx = cand[$urandom_range(0, cand.size() - 1)];
    off = 0;
    for (int i = 0; i < idx; i++) off += run_bytes_of(i);
    sz = run_bytes_of(idx);
    if (at_edge) run_off = $urandom_range(0, 1) ? 0 : sz - 1;
    else run_off = {$urandom, $urandom} % sz;
    p = off + run_off;
    if (p >= POS_LIMIT) return {1'b0, 47'({$urandom, $urandom})};
    return p[47:0];
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected transaction expected none actual status %0d", $time, status);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("status", 64'(want.status), 64'(status));
        compare_field("phys_position", 64'(want.phys), 64'(phys_position));
        compare_field("grant_length", 64'(want.grant), 64'(grant_length));
        compare_field("run_hit", 64'(want.hit), 64'(run_hit));
        compare_field("total_size", 64'(want.total), 64'(total_size));
      end
    end
  end

  always begin
    @(posedge clk);
    if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 17)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_transaction(emt_pkg::cmd_t c, logic [3:0] slot, logic [31:0] st,
                                  logic [31:0] len, logic [47:0] pos, logic [31:0] req);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    run_slot <= slot;
    run_start <= st;
    run_length <= len;
    byte_position <= pos;
    request_length <= req;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(predict_reply(c, slot, st, len, pos, req));
  endtask

  task automatic translate(logic [47:0] pos, logic [31:0] req);
    send_transaction(emt_pkg::CMD_TRANSLATE, 4'($urandom), $urandom, $urandom, pos, req);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(logic mode, logic [16:0] bs, logic [47:0] base, logic [4:0] cnt);
    cfg_write <= 1'b1;
    cfg_index <= emt_pkg::CFG_MAP_MODE;
    cfg_data <= 48'(mode);
    @(posedge clk);
    cfg_index <= emt_pkg::CFG_BLK_BYTES;
    cfg_data <= 48'(bs);
    @(posedge clk);
    cfg_index <= emt_pkg::CFG_PART_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= emt_pkg::CFG_RUN_COUNT;
    cfg_data <= 48'(cnt);
    @(posedge clk);
    cfg_write <= 1'b0;
    map_mode_q = mode;
    blk_bytes_q = bs;
    part_base_q = base;
    run_count_q = cnt;
  endtask

  task automatic test_empty_map();
    translate(48'd0, 32'd5);
    translate(48'hFFFF_FFFF_FFFF, 32'd5);
  endtask

  task automatic test_table_fill();
    logic [31:0] st, len;
    for (int i = 0; i < MAX_RUNS; i++) begin
      st = 32'(i * 4096 + 7);
      len = 32'd8;
      if (i == 0) begin
        st = '0;
        len = 32'd1;
      end
      // empty run in slot 1, widest run in the last slot
      if (i == 1) begin
        st = '1;
        len = '0;
      end
      if (i == MAX_RUNS - 1) begin
        st = '1;
        len = '1;
      end
      send_transaction(emt_pkg::CMD_WRITE, 4'(i), st, len, 48'({$urandom, $urandom}),
                       $urandom);
    end
  endtask

  task automatic test_block_mode();
    drain_pipeline();
    load_config(1'b0, 17'd512, 48'h1234_5678_9ABC, 5'd31);
    translate(48'd0, 32'd0);
    translate(48'd511, 32'hFFFF_FFFF);
    translate(48'd512, 32'd100);
    translate(48'(mapped_bytes() - 1), 32'hFFFF_FFFF);
    translate(48'(mapped_bytes()), 32'd1);
    translate(48'h7FFF_FFFF_FFFF, 32'd1);
    translate(48'h8000_0000_0000, 32'd1);
  endtask

  task automatic test_byte_mode();
    drain_pipeline();
    load_config(1'b1, 17'd512, 48'hFFFF_FFFF_FFFF, 5'd16);
    translate(48'd0, 32'hFFFF_FFFF);
    translate(48'd1, 32'd3);
  endtask

  task automatic test_block_size_extremes();
    drain_pipeline();
    load_config(1'b0, 17'd0, 48'd0, 5'd16);
    translate(48'd0, 32'd1);
    drain_pipeline();
    load_config(1'b0, 17'h1FFFF, 48'd0, 5'd16);
    translate(48'd12345, 32'd99);
  endtask

  task automatic run_traffic_phase(int item_total, int gap_level, int stall_level);
    logic [16:0] bs;
    logic [4:0]  cnt;
    logic [47:0] base, pos;
    logic [31:0] len, req;
    longint unsigned span;
    emt_pkg::cmd_t c;
    drain_pipeline();
    gap_pct = gap_level;
    stall_pct = stall_level;
    case ($urandom_range(0, 7))
      0: bs = 17'd0;
      1: bs = 17'd1;
      2: bs = 17'd512;
      3: bs = 17'd4096;
      4: bs = 17'd65536;
      5: bs = 17'h1FFFF;
      default: bs = 17'($urandom_range(1, 131071));
    endcase
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = '1;
      default: base = 48'({$urandom, $urandom});
    endcase
    case ($urandom_range(0, 9))
      0: cnt = 5'd0;
      1: cnt = 5'($urandom_range(17, 31));
      default: cnt = 5'($urandom_range(1, 16));
    endcase
    load_config(1'($urandom_range(0, 1)), bs, base, cnt);
    for (int k = 0; k < item_total; k++) begin
      case ($urandom_range(0, 7))
        0: req = '0;
        1: req = '1;
        2, 3: req = $urandom;
        default: req = 32'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 9))
        0: len = '0;
        1, 2, 3, 4, 5: len = 32'($urandom_range(1, 64));
        6, 7: len = 32'($urandom_range(1, 65535));
        8: len = $urandom;
        default: len = '1;
      endcase
      c = emt_pkg::CMD_TRANSLATE;
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          c = emt_pkg::CMD_WRITE;
          pos = 48'({$urandom, $urandom});
        end
        3, 4: pos = {1'b1, 47'({$urandom, $urandom})};
        5: pos = {1'b0, 47'({$urandom, $urandom})};
        6: begin
          span = mapped_bytes();
          pos = (span < POS_LIMIT) ? span[47:0] : {1'b0, 47'({$urandom, $urandom})};
        end
        7, 8, 9: pos = pick_target(1'b1);
        default: pos = pick_target(1'b0);
      endcase
      send_transaction(c, 4'($urandom), $urandom, len, pos, req);
      if ($urandom_range(0, 99) == 0) drain_pipeline();
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 11; p++)
      run_traffic_phase(150, 15 * $urandom_range(0, 4), 15 * $urandom_range(0, 4));
  endtask

  task automatic test_back_to_back();
    run_traffic_phase(150, 0, 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_map();
    test_table_fill();
    test_block_mode();
    test_byte_mode();
    test_block_size_extremes();
    test_random_traffic();
    test_back_to_back();
    drain_pipeline();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("extent_map_translator_top_tb OK");
    end else begin
      $display("extent_map_translator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/emt_pkg.sv
rtl/emt_front.sv
rtl/emt_queue.sv
rtl/emt_back.sv
rtl/extent_map_translator_top.sv
sim/extent_map_translator_top_tb.sv
